// File: rtl/cds_pkg.sv
// Shared codes, limits and the month length table for the calendar date stepper.
package cds_pkg;

  localparam int unsigned YearBitsDefault = 8;

  localparam logic [2:0] REQ_ADD_TICK  = 3'd0;
  localparam logic [2:0] REQ_ADD_DAY   = 3'd1;
  localparam logic [2:0] REQ_SUB_DAY   = 3'd2;
  localparam logic [2:0] REQ_ADD_MONTH = 3'd3;
  localparam logic [2:0] REQ_SUB_MONTH = 3'd4;

  localparam logic [6:0] TickLast      = 7'd95;
  localparam logic [3:0] MonthsPerYear = 4'd12;
  localparam logic [3:0] MonthFeb      = 4'd2;
  localparam logic [1:0] LeapMask      = 2'b11;

  // Length of a month; codes outside 1..12 count as zero days.
  function automatic logic [4:0] days_in(input logic leap, input logic [3:0] month);
    logic [4:0] len;
    begin
      case (month)
        4'd1:    len = 5'd31;
        4'd2:    len = 5'd28;
        4'd3:    len = 5'd31;
        4'd4:    len = 5'd30;
        4'd5:    len = 5'd31;
        4'd6:    len = 5'd30;
        4'd7:    len = 5'd31;
        4'd8:    len = 5'd31;
        4'd9:    len = 5'd30;
        4'd10:   len = 5'd31;
        4'd11:   len = 5'd30;
        4'd12:   len = 5'd31;
        default: len = 5'd0;
      endcase
      if (month == MonthFeb && leap) begin
        len = len + 5'd1;
      end
      days_in = len;
    end
  endfunction

endpackage

// File: rtl/calendar_date_step.sv
// Calendar date stepper: three-stage pipeline applying one tick, day or month step.
// A request taken passes through the s1, s2 and out registers and then shows its result on
// the outputs with valid_o high. Throughput: one request per cycle.
// busy is always low; the result strobe cannot be held off, so the pipe never stalls.
// Reset (asynchronous, active low) clears the stage valid bits only.
module calendar_date_step #(
  parameter int unsigned YEAR_BITS = cds_pkg::YearBitsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [2:0]           req_type_i,
  input  logic [YEAR_BITS-1:0] year_in_i,
  input  logic [3:0]           month_in_i,
  input  logic [4:0]           day_in_i,
  input  logic [6:0]           tick_in_i,
  output logic                 valid_o,
  output logic [YEAR_BITS-1:0] year_out_o,
  output logic [3:0]           month_out_o,
  output logic [4:0]           day_out_o,
  output logic [6:0]           tick_out_o
);
  import cds_pkg::*;

  typedef logic [YEAR_BITS-1:0] year_t;

  // Stage 1: tick step and both month neighbors.
  typedef struct packed {
    logic [2:0] req;
    year_t      year;
    logic [3:0] month;
    logic [4:0] day;
    logic [6:0] tick;
    logic [6:0] tick_nxt;
    logic       tick_wrap;
    year_t      year_inc;
    logic [3:0] month_inc;
    year_t      year_dec;
    logic [3:0] month_dec;
  } s1_t;

  // Stage 2: day roll decisions and previous month length.
  typedef struct packed {
    logic [2:0] req;
    year_t      year;
    logic [3:0] month;
    logic [4:0] day;
    logic [6:0] tick;
    logic [6:0] tick_nxt;
    logic       tick_wrap;
    year_t      year_inc;
    logic [3:0] month_inc;
    year_t      year_dec;
    logic [3:0] month_dec;
    logic       day_roll;
    logic       day_low;
    logic [4:0] len_dec;
  } s2_t;

  typedef struct packed {
    year_t      year;
    logic [3:0] month;
    logic [4:0] day;
    logic [6:0] tick;
  } res_t;

  logic s1_vld_q, s2_vld_q, out_vld_q;
  s1_t  s1_d, s1_q;
  s2_t  s2_d, s2_q;
  res_t out_d, out_q;
  logic accept;
  logic [5:0] day_plus;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  always_comb begin
    s1_d.req       = req_type_i;
    s1_d.year      = year_in_i;
    s1_d.month     = month_in_i;
    s1_d.day       = day_in_i;
    s1_d.tick      = tick_in_i;
    s1_d.tick_wrap = (tick_in_i >= TickLast);
    s1_d.tick_nxt  = s1_d.tick_wrap ? 7'd0 : tick_in_i + 7'd1;
    if (month_in_i >= MonthsPerYear) begin
      s1_d.month_inc = 4'd1;
      s1_d.year_inc  = year_in_i + year_t'(1);
    end else begin
      s1_d.month_inc = month_in_i + 4'd1;
      s1_d.year_inc  = year_in_i;
    end
    if (month_in_i <= 4'd1) begin
      s1_d.month_dec = MonthsPerYear;
      s1_d.year_dec  = year_in_i - year_t'(1);
    end else if (month_in_i > MonthsPerYear) begin
      s1_d.month_dec = MonthsPerYear;
      s1_d.year_dec  = year_in_i;
    end else begin
      s1_d.month_dec = month_in_i - 4'd1;
      s1_d.year_dec  = year_in_i;
    end
  end

  always_comb begin
    day_plus       = {1'b0, s1_q.day} + 6'd1;
    s2_d.req       = s1_q.req;
    s2_d.year      = s1_q.year;
    s2_d.month     = s1_q.month;
    s2_d.day       = s1_q.day;
    s2_d.tick      = s1_q.tick;
    s2_d.tick_nxt  = s1_q.tick_nxt;
    s2_d.tick_wrap = s1_q.tick_wrap;
    s2_d.year_inc  = s1_q.year_inc;
    s2_d.month_inc = s1_q.month_inc;
    s2_d.year_dec  = s1_q.year_dec;
    s2_d.month_dec = s1_q.month_dec;
    s2_d.day_roll  = day_plus >
                     {1'b0, days_in((s1_q.year[1:0] & LeapMask) == 2'b00, s1_q.month)};
    s2_d.day_low   = (s1_q.day <= 5'd1);
    s2_d.len_dec   = days_in((s1_q.year_dec[1:0] & LeapMask) == 2'b00, s1_q.month_dec);
  end

  always_comb begin
    out_d.year  = s2_q.year;
    out_d.month = s2_q.month;
    out_d.day   = s2_q.day;
    // Non-tick requests pass the tick through untouched.
    out_d.tick  = s2_q.tick;
    case (s2_q.req)
      REQ_ADD_TICK: begin
        out_d.tick = s2_q.tick_nxt;
        if (s2_q.tick_wrap) begin
          if (s2_q.day_roll) begin
            out_d.day   = 5'd1;
            out_d.year  = s2_q.year_inc;
            out_d.month = s2_q.month_inc;
          end else begin
            out_d.day = s2_q.day + 5'd1;
          end
        end
      end
      REQ_ADD_DAY: begin
        if (s2_q.day_roll) begin
          out_d.day   = 5'd1;
          out_d.year  = s2_q.year_inc;
          out_d.month = s2_q.month_inc;
        end else begin
          out_d.day = s2_q.day + 5'd1;
        end
      end
      REQ_SUB_DAY: begin
        if (s2_q.day_low) begin
          out_d.day   = s2_q.len_dec;
          out_d.year  = s2_q.year_dec;
          out_d.month = s2_q.month_dec;
        end else begin
          out_d.day = s2_q.day - 5'd1;
        end
      end
      REQ_ADD_MONTH: begin
        out_d.year  = s2_q.year_inc;
        out_d.month = s2_q.month_inc;
      end
      REQ_SUB_MONTH: begin
        out_d.year  = s2_q.year_dec;
        out_d.month = s2_q.month_dec;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      s1_vld_q  <= accept;
      s2_vld_q  <= s1_vld_q;
      out_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= s1_d;
    end
    if (s1_vld_q) begin
      s2_q <= s2_d;
    end
    if (s2_vld_q) begin
      out_q <= out_d;
    end
  end

  assign valid_o     = out_vld_q;
  assign year_out_o  = out_q.year;
  assign month_out_o = out_q.month;
  assign day_out_o   = out_q.day;
  assign tick_out_o  = out_q.tick;

endmodule
